// ----- rtl/link_and_host_watchdog_supervisor_macros.svh -----
// Assertion macros for the link and host watchdog supervisor.
`ifndef LINK_AND_HOST_WATCHDOG_SUPERVISOR_MACROS_SVH
`define LINK_AND_HOST_WATCHDOG_SUPERVISOR_MACROS_SVH

`ifndef ASSERT_OFF
`define LHWS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
`define LHWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LHWS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define LHWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- rtl/lhws_pkg.sv -----
package lhws_pkg;

	localparam int ACT_W      = 2;
	localparam int BYTE_W     = 6;
	localparam int CLK_W      = 20;
	localparam int MIN_W      = 10;
	localparam int TMR_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int PROD_W     = 20;
	localparam int DIV_STEPS  = PROD_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	typedef enum logic [ACT_W-1:0] {
		ACT_TICK  = 2'd0,
		ACT_DONE  = 2'd1,
		ACT_ERROR = 2'd2,
		ACT_START = 2'd3
	} action_t;

	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POWER   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REBOOT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CONTACT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LED     = 3'd6;

	localparam logic [CLK_W-1:0] RST_CLOCK   = 20'd100000;
	localparam logic [MIN_W-1:0] RST_MIN     = 10'd20;
	localparam logic [TMR_W-1:0] RST_IDLE    = 16'd100;
	localparam logic [TMR_W-1:0] RST_POWER   = 16'd100;
	localparam logic [TMR_W-1:0] RST_REBOOT  = 16'd30000;
	localparam logic [TMR_W-1:0] RST_CONTACT = 16'd2000;
	localparam logic [TMR_W-1:0] RST_LED     = 16'd1000;

	localparam logic [TMR_W-1:0]  STOP_RELOAD = 16'd100;
	localparam logic [PROD_W-1:0] BYTE_MS     = 20'd9000;
	localparam logic [7:0]        MAX_BYTES   = 8'd63;

	typedef struct packed {
		logic accept;
		logic div_start;
		logic apply_timeout;
		logic load_out;
	} lhws_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} lhws_sts_t;

endpackage

// ----- rtl/link_and_host_watchdog_supervisor.sv -----
// A tick, done or error transaction moves from the idle state to the result state on acceptance.
// A start transaction first runs the 20 steps of the serial divider for the timeout, applies it
// and then moves to the result state. In the result state the result is registered once the
// previous result has been taken or out_ready is high. One transaction is in work at a time:
// the next is taken only after the result is registered, so a low out_ready can hold the input.
// Reset is asynchronous and active low; it loads the register and timer reset values.
`include "link_and_host_watchdog_supervisor_macros.svh"

module link_and_host_watchdog_supervisor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lhws_pkg::ACT_W-1:0]        action,
	input  logic [lhws_pkg::BYTE_W-1:0]       byte_count,
	input  logic                              power_good,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              bus_reset,
	output logic                              host_reset,
	output logic                              host_connected,
	output logic                              backup_enable,
	output logic                              led_level,
	output logic                              transfer_active,
	output logic [lhws_pkg::TMR_W-1:0]        error_total,
	input  logic                              cfg_we,
	input  logic [lhws_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lhws_pkg::CFG_DATA_W-1:0]   cfg_data
);

	lhws_pkg::lhws_cmd_t cmd;
	lhws_pkg::lhws_sts_t sts;

	lhws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lhws_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.action          (action),
		.byte_count      (byte_count),
		.power_good      (power_good),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.bus_reset       (bus_reset),
		.host_reset      (host_reset),
		.host_connected  (host_connected),
		.backup_enable   (backup_enable),
		.led_level       (led_level),
		.transfer_active (transfer_active),
		.error_total     (error_total)
	);

	`LHWS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "input ready straight after a transaction was accepted")
	`LHWS_ASSERT_NEXT(a_load_gives_valid, clk, arst_n, cmd.load_out, out_valid, "result load did not raise out_valid")
	`LHWS_ASSERT_NEXT(a_backup_sticky, clk, arst_n, out_valid && backup_enable, backup_enable, "backup_enable fell after being latched")
	`LHWS_ASSERT_SAME(a_no_apply_when_idle, clk, arst_n, cmd.apply_timeout, !in_ready && !cmd.load_out, "timeout applied outside the division phase")

endmodule

// ----- rtl/lhws_div.sv -----
module lhws_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lhws_pkg::PROD_W-1:0]       dividend,
	input  logic [lhws_pkg::CLK_W-1:0]        divisor,
	output logic                              done,
	output logic [lhws_pkg::PROD_W-1:0]       quotient
);

	logic [lhws_pkg::PROD_W:0]           rem_q;
	logic [lhws_pkg::PROD_W-1:0]         quo_q;
	logic [lhws_pkg::CLK_W-1:0]          den_q;
	logic [lhws_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic                                busy_q;
	logic                                done_q;
	logic [lhws_pkg::PROD_W:0]           rem_shift;
	logic [lhws_pkg::PROD_W:0]           rem_trial;
	logic                                fits;

	always_comb begin
		rem_shift = {rem_q[lhws_pkg::PROD_W-1:0], quo_q[lhws_pkg::PROD_W-1]};
		fits      = rem_shift >= {1'b0, den_q};
		rem_trial = rem_shift - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == lhws_pkg::DIV_CNT_W'(lhws_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_trial : rem_shift;
			quo_q <= {quo_q[lhws_pkg::PROD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/lhws_ctrl.sv -----
module lhws_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [lhws_pkg::ACT_W-1:0]    action,
	output logic                          in_ready,
	input  lhws_pkg::lhws_sts_t           sts,
	output lhws_pkg::lhws_cmd_t           cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_RES
	} state_t;

	state_t state_q;
	logic   accept;
	logic   is_start;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign is_start = (lhws_pkg::action_t'(action) == lhws_pkg::ACT_START);

	always_comb begin
		cmd.accept        = accept;
		cmd.div_start     = accept && is_start;
		cmd.apply_timeout = (state_q == ST_DIV) && sts.div_done;
		cmd.load_out      = (state_q == ST_RES) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= is_start ? ST_DIV : ST_RES;
					end
				end
				ST_DIV: begin
					if (sts.div_done) begin
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/lhws_dp.sv -----
module lhws_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lhws_pkg::lhws_cmd_t               cmd,
	output lhws_pkg::lhws_sts_t               sts,
	input  logic [lhws_pkg::ACT_W-1:0]        action,
	input  logic [lhws_pkg::BYTE_W-1:0]       byte_count,
	input  logic                              power_good,
	input  logic                              cfg_we,
	input  logic [lhws_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lhws_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              bus_reset,
	output logic                              host_reset,
	output logic                              host_connected,
	output logic                              backup_enable,
	output logic                              led_level,
	output logic                              transfer_active,
	output logic [lhws_pkg::TMR_W-1:0]        error_total
);

	localparam int TW = lhws_pkg::TMR_W;

	logic [lhws_pkg::CLK_W-1:0] reg_clock_q;
	logic [lhws_pkg::MIN_W-1:0] reg_min_q;
	logic [TW-1:0]              reg_idle_q;
	logic [TW-1:0]              reg_power_q;
	logic [TW-1:0]              reg_reboot_q;
	logic [TW-1:0]              reg_contact_q;
	logic [TW-1:0]              reg_led_q;

	logic [TW-1:0] idle_q, idle_n;
	logic [TW-1:0] act_tmr_q, act_tmr_n;
	logic          armed_q, armed_n;
	logic [TW-1:0] power_q, power_n;
	logic          backup_q, backup_n;
	logic [TW-1:0] host_q, host_n;
	logic          alive_q, alive_n;
	logic [TW-1:0] led_div_q, led_div_n;
	logic          led_q, led_n;
	logic [TW-1:0] err_q, err_n;
	logic          bus_p_q, bus_p_n;
	logic          host_p_q, host_p_n;

	logic [TW-1:0] led_inc;
	logic [TW-1:0] idle_dec;
	logic [TW-1:0] host_dec;

	logic [lhws_pkg::BYTE_W-1:0] bytes_eff;
	logic [lhws_pkg::PROD_W-1:0] dividend;
	logic [lhws_pkg::PROD_W-1:0] quotient;
	logic                        div_done;
	logic [TW-1:0]               quo_sat;
	logic [TW:0]                 tmo_sum;
	logic [TW-1:0]               timeout;

	logic          out_valid_q;
	logic          bus_reset_q;
	logic          host_reset_q;
	logic          host_connected_q;
	logic          backup_enable_q;
	logic          led_level_q;
	logic          transfer_active_q;
	logic [TW-1:0] error_total_q;

	assign bytes_eff = ({2'b00, byte_count} > lhws_pkg::MAX_BYTES) ?
		lhws_pkg::MAX_BYTES[lhws_pkg::BYTE_W-1:0] : byte_count;
	assign dividend  = {{(lhws_pkg::PROD_W - lhws_pkg::BYTE_W){1'b0}}, bytes_eff} *
		lhws_pkg::BYTE_MS;

	lhws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (reg_clock_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign quo_sat = (|quotient[lhws_pkg::PROD_W-1:TW]) ? '1 : quotient[TW-1:0];
	assign tmo_sum = {{(TW + 1 - lhws_pkg::MIN_W){1'b0}}, reg_min_q} + {1'b0, quo_sat};
	assign timeout = tmo_sum[TW] ? '1 : tmo_sum[TW-1:0];

	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;

	assign led_inc  = led_div_q + 1'b1;
	assign idle_dec = (idle_q != '0) ? idle_q - 1'b1 : idle_q;
	assign host_dec = (host_q != '0) ? host_q - 1'b1 : host_q;

	always_comb begin
		idle_n    = idle_q;
		act_tmr_n = act_tmr_q;
		armed_n   = armed_q;
		power_n   = power_q;
		backup_n  = backup_q;
		host_n    = host_q;
		alive_n   = alive_q;
		led_div_n = led_div_q;
		led_n     = led_q;
		err_n     = err_q;
		bus_p_n   = bus_p_q;
		host_p_n  = host_p_q;
		if (cmd.accept) begin
			bus_p_n  = 1'b0;
			host_p_n = 1'b0;
			case (lhws_pkg::action_t'(action))
				lhws_pkg::ACT_TICK: begin
					led_div_n = led_inc;
					if (led_inc >= reg_led_q) begin
						led_n     = alive_q ? 1'b0 : !led_q;
						led_div_n = '0;
					end
					idle_n = idle_dec;
					if (idle_dec == '0) begin
						bus_p_n   = 1'b1;
						idle_n    = reg_idle_q;
						armed_n   = 1'b0;
						act_tmr_n = lhws_pkg::STOP_RELOAD;
					end
					if (armed_n && (act_tmr_n != '0)) begin
						act_tmr_n = act_tmr_n - 1'b1;
						if (act_tmr_n == '0) begin
							bus_p_n   = 1'b1;
							idle_n    = reg_idle_q;
							armed_n   = 1'b0;
							act_tmr_n = lhws_pkg::STOP_RELOAD;
						end
					end
					if (power_q != '0) begin
						power_n = power_q - 1'b1;
						if (power_q == TW'(1)) begin
							backup_n = 1'b1;
						end
					end
					if (power_good) begin
						power_n = reg_power_q;
					end
					host_n = host_dec;
					if (host_dec == '0) begin
						host_p_n = 1'b1;
						alive_n  = 1'b0;
						host_n   = reg_reboot_q;
					end
				end
				lhws_pkg::ACT_DONE: begin
					alive_n   = 1'b1;
					host_n    = reg_contact_q;
					idle_n    = reg_idle_q;
					armed_n   = 1'b0;
					act_tmr_n = lhws_pkg::STOP_RELOAD;
				end
				lhws_pkg::ACT_ERROR: begin
					armed_n   = 1'b0;
					act_tmr_n = lhws_pkg::STOP_RELOAD;
					if (err_q != '1) begin
						err_n = err_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.apply_timeout) begin
			act_tmr_n = timeout;
			armed_n   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_clock_q   <= lhws_pkg::RST_CLOCK;
			reg_min_q     <= lhws_pkg::RST_MIN;
			reg_idle_q    <= lhws_pkg::RST_IDLE;
			reg_power_q   <= lhws_pkg::RST_POWER;
			reg_reboot_q  <= lhws_pkg::RST_REBOOT;
			reg_contact_q <= lhws_pkg::RST_CONTACT;
			reg_led_q     <= lhws_pkg::RST_LED;
		end else if (cfg_we) begin
			case (cfg_index)
				lhws_pkg::CFG_CLOCK:   reg_clock_q   <= cfg_data[lhws_pkg::CLK_W-1:0];
				lhws_pkg::CFG_MIN:     reg_min_q     <= cfg_data[lhws_pkg::MIN_W-1:0];
				lhws_pkg::CFG_IDLE:    reg_idle_q    <= cfg_data[TW-1:0];
				lhws_pkg::CFG_POWER:   reg_power_q   <= cfg_data[TW-1:0];
				lhws_pkg::CFG_REBOOT:  reg_reboot_q  <= cfg_data[TW-1:0];
				lhws_pkg::CFG_CONTACT: reg_contact_q <= cfg_data[TW-1:0];
				lhws_pkg::CFG_LED:     reg_led_q     <= cfg_data[TW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q    <= lhws_pkg::RST_IDLE;
			act_tmr_q <= '0;
			armed_q   <= 1'b0;
			power_q   <= lhws_pkg::RST_POWER;
			backup_q  <= 1'b0;
			host_q    <= lhws_pkg::RST_REBOOT;
			alive_q   <= 1'b0;
			led_div_q <= '0;
			led_q     <= 1'b0;
			err_q     <= '0;
			bus_p_q   <= 1'b0;
			host_p_q  <= 1'b0;
		end else begin
			idle_q    <= idle_n;
			act_tmr_q <= act_tmr_n;
			armed_q   <= armed_n;
			power_q   <= power_n;
			backup_q  <= backup_n;
			host_q    <= host_n;
			alive_q   <= alive_n;
			led_div_q <= led_div_n;
			led_q     <= led_n;
			err_q     <= err_n;
			bus_p_q   <= bus_p_n;
			host_p_q  <= host_p_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			bus_reset_q       <= bus_p_q;
			host_reset_q      <= host_p_q;
			host_connected_q  <= alive_q;
			backup_enable_q   <= backup_q;
			led_level_q       <= led_q;
			transfer_active_q <= armed_q;
			error_total_q     <= err_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign bus_reset       = bus_reset_q;
	assign host_reset      = host_reset_q;
	assign host_connected  = host_connected_q;
	assign backup_enable   = backup_enable_q;
	assign led_level       = led_level_q;
	assign transfer_active = transfer_active_q;
	assign error_total     = error_total_q;

endmodule

// ----- verif/supervisor_monitor.sv -----
`timescale 1ns / 1ps

module supervisor_monitor
	import lhws_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [ACT_W-1:0]      action,
	input  logic [BYTE_W-1:0]     byte_count,
	input  logic                  power_good,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic                  bus_reset,
	input  logic                  host_reset,
	input  logic                  host_connected,
	input  logic                  backup_enable,
	input  logic                  led_level,
	input  logic                  transfer_active,
	input  logic [TMR_W-1:0]      error_total,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           failures,
	output int unsigned           outstanding
);

	typedef struct packed {
		logic             bus_rst;
		logic             host_rst;
		logic             connected;
		logic             backup;
		logic             led;
		logic             active;
		logic [TMR_W-1:0] errors;
	} supervisor_status_t;

	logic [CLK_W-1:0] clk_hz;
	logic [MIN_W-1:0] min_ms;
	logic [TMR_W-1:0] idle_lim, power_off, reboot_ms, contact_ms, led_period;

	logic [TMR_W-1:0] idle_cnt, xfer_cnt, power_cnt, host_cnt, led_div, err_cnt;
	logic             xfer_armed, backup_on, host_alive, led_on;

	supervisor_status_t status_due[$];
	int unsigned        fail_total;

	function automatic string status_text(supervisor_status_t s);
		return $sformatf("bus %b host %b conn %b backup %b led %b active %b errors %0d",
			s.bus_rst, s.host_rst, s.connected, s.backup, s.led, s.active, s.errors);
	endfunction

	task automatic reload_link_watch();
		idle_cnt   = idle_lim;
		xfer_armed = 1'b0;
		xfer_cnt   = STOP_RELOAD;
	endtask

	task automatic advance_supervisor(input action_t act, input logic [BYTE_W-1:0] bytes,
			input logic pg, output supervisor_status_t s);
		logic [7:0]  n;
		int unsigned prod, quot, span;
		s = '0;
		case (act)
			ACT_TICK: begin
				led_div = led_div + 16'd1;
				if (led_div >= led_period) begin
					led_on  = host_alive ? 1'b0 : ~led_on;
					led_div = '0;
				end
				if (idle_cnt != 0)
					idle_cnt = idle_cnt - 16'd1;
				if (idle_cnt == 0) begin
					s.bus_rst = 1'b1;
					reload_link_watch();
				end
				if (xfer_cnt != 0 && xfer_armed) begin
					xfer_cnt = xfer_cnt - 16'd1;
					if (xfer_cnt == 0) begin
						s.bus_rst = 1'b1;
						reload_link_watch();
					end
				end
				if (power_cnt != 0) begin
					power_cnt = power_cnt - 16'd1;
					if (power_cnt == 0)
						backup_on = 1'b1;
				end
				if (pg)
					power_cnt = power_off;
				if (host_cnt != 0)
					host_cnt = host_cnt - 16'd1;
				if (host_cnt == 0) begin
					s.host_rst = 1'b1;
					host_alive = 1'b0;
					host_cnt   = reboot_ms;
				end
			end
			ACT_DONE: begin
				host_alive = 1'b1;
				host_cnt   = contact_ms;
				reload_link_watch();
			end
			ACT_ERROR: begin
				xfer_armed = 1'b0;
				xfer_cnt   = STOP_RELOAD;
				if (err_cnt != 16'hFFFF)
					err_cnt = err_cnt + 16'd1;
			end
			default: begin
				n = 8'(bytes);
				if (n > MAX_BYTES)
					n = MAX_BYTES;
				prod = int'(n) * int'(BYTE_MS);
				if (clk_hz == 0)
					quot = 32'hFFFF;
				else
					quot = prod / int'(clk_hz);
				if (quot > 32'hFFFF)
					quot = 32'hFFFF;
				span = int'(min_ms) + quot;
				if (span > 32'hFFFF)
					span = 32'hFFFF;
				xfer_cnt   = span[TMR_W-1:0];
				xfer_armed = 1'b1;
			end
		endcase
		s.connected = host_alive;
		s.backup    = backup_on;
		s.led       = led_on;
		s.active    = xfer_armed;
		s.errors    = err_cnt;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		supervisor_status_t seen, due;
		if (!arst_n) begin
			clk_hz     = RST_CLOCK;
			min_ms     = RST_MIN;
			idle_lim   = RST_IDLE;
			power_off  = RST_POWER;
			reboot_ms  = RST_REBOOT;
			contact_ms = RST_CONTACT;
			led_period = RST_LED;
			idle_cnt   = RST_IDLE;
			xfer_cnt   = '0;
			xfer_armed = 1'b0;
			power_cnt  = RST_POWER;
			backup_on  = 1'b0;
			host_cnt   = RST_REBOOT;
			host_alive = 1'b0;
			led_div    = '0;
			led_on     = 1'b0;
			err_cnt    = '0;
			status_due.delete();
			fail_total = 0;
			failures    <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CLOCK:   clk_hz     = cfg_data[CLK_W-1:0];
					CFG_MIN:     min_ms     = cfg_data[MIN_W-1:0];
					CFG_IDLE:    idle_lim   = cfg_data[TMR_W-1:0];
					CFG_POWER:   power_off  = cfg_data[TMR_W-1:0];
					CFG_REBOOT:  reboot_ms  = cfg_data[TMR_W-1:0];
					CFG_CONTACT: contact_ms = cfg_data[TMR_W-1:0];
					CFG_LED:     led_period = cfg_data[TMR_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				advance_supervisor(action_t'(action), byte_count, power_good, due);
				status_due.push_back(due);
			end
			if (out_valid && out_ready) begin
				seen = {bus_reset, host_reset, host_connected, backup_enable, led_level,
					transfer_active, error_total};
				if (status_due.size() == 0) begin
					if (fail_total < 10)
						$display("%0t: result with no transaction pending: %s", $realtime,
							status_text(seen));
					fail_total++;
				end else begin
					due = status_due.pop_front();
					if (seen !== due) begin
						if (fail_total < 10)
							$display("%0t: status mismatch, expected %s, got %s", $realtime,
								status_text(due), status_text(seen));
						fail_total++;
					end
				end
			end
			failures    <= fail_total;
			outstanding <= status_due.size();
		end
	end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import lhws_pkg::*;

	localparam int unsigned WATCH_LIMIT = 5000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [ACT_W-1:0]      action;
	logic [BYTE_W-1:0]     byte_count;
	logic                  power_good;
	logic                  out_valid;
	logic                  out_ready;
	logic                  bus_reset;
	logic                  host_reset;
	logic                  host_connected;
	logic                  backup_enable;
	logic                  led_level;
	logic                  transfer_active;
	logic [TMR_W-1:0]      error_total;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int unsigned failures;
	int unsigned outstanding;
	int unsigned send_idle;
	int unsigned recv_idle;
	int unsigned quiet_cycles;

	link_and_host_watchdog_supervisor dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.byte_count      (byte_count),
		.power_good      (power_good),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.bus_reset       (bus_reset),
		.host_reset      (host_reset),
		.host_connected  (host_connected),
		.backup_enable   (backup_enable),
		.led_level       (led_level),
		.transfer_active (transfer_active),
		.error_total     (error_total),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	supervisor_monitor monitor (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.byte_count      (byte_count),
		.power_good      (power_good),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.bus_reset       (bus_reset),
		.host_reset      (host_reset),
		.host_connected  (host_connected),
		.backup_enable   (backup_enable),
		.led_level       (led_level),
		.transfer_active (transfer_active),
		.error_total     (error_total),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.failures        (failures),
		.outstanding     (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCH_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input action_t act, input logic [BYTE_W-1:0] bytes, input logic pg);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		byte_count <= bytes;
		power_good <= pg;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_random();
		int unsigned pick;
		action_t     act;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			act = ACT_TICK;
		else if (pick < 72)
			act = ACT_DONE;
		else if (pick < 82)
			act = ACT_ERROR;
		else
			act = ACT_START;
		send_item(act, BYTE_W'($urandom_range(0, 63)), $urandom_range(0, 99) < 90);
	endtask

	// The block is idle once every transaction has produced its result.
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_registers(input logic [CFG_DATA_W-1:0] clk_v, min_v, idle_v, pwr_v,
			boot_v, cont_v, led_v);
		logic [CFG_IDX_W-1:0]  idx [8];
		logic [CFG_DATA_W-1:0] val [8];
		idx = '{CFG_CLOCK, CFG_MIN, CFG_IDLE, CFG_POWER, CFG_REBOOT, CFG_CONTACT, CFG_LED,
			CFG_SPARE};
		val = '{clk_v, min_v, idle_v, pwr_v, boot_v, cont_v, led_v,
			CFG_DATA_W'($urandom_range(0, 20'hFFFFF))};
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic write_random_registers();
		logic [CFG_DATA_W-1:0] clk_v;
		logic [CFG_DATA_W-1:0] min_v;
		case ($urandom_range(0, 9))
			0:       clk_v = '0;
			1:       clk_v = 20'hFFFFF;
			2, 3:    clk_v = CFG_DATA_W'($urandom_range(1, 2000));
			default: clk_v = CFG_DATA_W'($urandom_range(10000, 1000000));
		endcase
		min_v = ($urandom_range(0, 9) == 0) ? 20'd1023 : CFG_DATA_W'($urandom_range(0, 30));
		write_registers(clk_v, min_v, CFG_DATA_W'($urandom_range(0, 60)),
			CFG_DATA_W'($urandom_range(10, 200)), CFG_DATA_W'($urandom_range(0, 80)),
			CFG_DATA_W'($urandom_range(1, 80)), CFG_DATA_W'($urandom_range(0, 6)));
	endtask

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		action     <= ACT_TICK;
		byte_count <= '0;
		power_good <= 1'b1;
		out_ready  <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= CFG_CLOCK;
		cfg_data   <= '0;
		send_idle = 29;
		recv_idle = 55;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(ACT_TICK, 6'd0, 1'b1);
		send_item(ACT_TICK, 6'd0, 1'b0);
		send_item(ACT_START, 6'd63, 1'b1);
		send_item(ACT_TICK, 6'd63, 1'b1);
		send_item(ACT_DONE, 6'd0, 1'b1);
		send_item(ACT_ERROR, 6'd0, 1'b1);
		send_item(ACT_START, 6'd0, 1'b0);

		// Zero clock and zero reloads: saturated timeout, pulses on every tick.
		settle();
		write_registers(20'd0, 20'd1023, 20'd0, 20'd1, 20'd0, 20'd1, 20'd0);
		send_item(ACT_START, 6'd63, 1'b1);
		send_item(ACT_DONE, 6'd0, 1'b1);
		repeat (4) send_item(ACT_TICK, 6'd0, 1'b1);

		// A zero timeout stays armed until a done or an error arrives.
		settle();
		write_registers(20'hFFFFF, 20'd0, 20'd65535, 20'd65535, 20'd65535, 20'd65535,
			20'd65535);
		send_item(ACT_DONE, 6'd0, 1'b1);
		send_item(ACT_START, 6'd0, 1'b1);
		send_item(ACT_TICK, 6'd0, 1'b1);
		send_item(ACT_TICK, 6'd0, 1'b1);
		send_item(ACT_START, 6'd63, 1'b1);
		send_item(ACT_TICK, 6'd0, 1'b1);
		send_item(ACT_ERROR, 6'd0, 1'b1);
		send_item(ACT_TICK, 6'd0, 1'b1);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 29 : (phase == 1) ? 55 : 0;
			recv_idle = (phase == 0) ? 55 : (phase == 1) ? 29 : 0;
			for (int chunk = 0; chunk < 3; chunk++) begin
				settle();
				write_random_registers();
				repeat (48) send_random();
			end
		end

		// Loss of power with a one-tick reload latches the backup supply.
		settle();
		write_registers(20'd100000, 20'd20, 20'd65535, 20'd1, 20'd65535, 20'd65535, 20'd3);
		send_item(ACT_TICK, 6'd0, 1'b1);
		send_item(ACT_TICK, 6'd0, 1'b0);
		send_item(ACT_TICK, 6'd0, 1'b0);
		send_item(ACT_TICK, 6'd0, 1'b1);

		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (25) @(posedge clk);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/lhws_pkg.sv
rtl/lhws_div.sv
rtl/lhws_ctrl.sv
rtl/lhws_dp.sv
rtl/link_and_host_watchdog_supervisor.sv
verif/supervisor_monitor.sv
verif/testbench.sv
